// ----- rtl/usb_control_request_responder_assert.svh -----
// Assertion macros used by the endpoint-0 request responder engine.
`ifndef USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH
`define USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define UCRR_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define UCRR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/ucrr_pkg.sv -----
// Types, codes and source lengths for the endpoint-0 request responder.
`default_nettype none
package ucrr_pkg;

    // Request type field of bmRequestType.
    localparam logic [7:0] TYPE_MASK     = 8'h60;
    localparam logic [7:0] TYPE_STANDARD = 8'h00;
    localparam logic [7:0] TYPE_VENDOR   = 8'h40;

    // Request codes.
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
    localparam logic [7:0] REQ_VENDOR_FEATURE    = 8'hAA;

    // Descriptor types and special indexes.
    localparam logic [7:0]  DT_DEVICE     = 8'd1;
    localparam logic [7:0]  DT_CONFIG     = 8'd2;
    localparam logic [7:0]  DT_STRING     = 8'd3;
    localparam logic [7:0]  DT_BOS        = 8'd15;
    localparam logic [7:0]  STR_LAST      = 8'd3;
    localparam logic [7:0]  STR_OS        = 8'hEE;
    localparam logic [15:0] VIDX_COMPAT   = 16'd4;
    localparam logic [15:0] VIDX_PROPS    = 16'd5;

    // Opcode of an input request.
    localparam logic OP_SETUP     = 1'b0;
    localparam logic OP_BUS_EVENT = 1'b1;

    // Data sources.
    localparam logic [3:0] SRC_DEVICE  = 4'd0;
    localparam logic [3:0] SRC_CONFIG  = 4'd1;
    localparam logic [3:0] SRC_BOS     = 4'd2;
    localparam logic [3:0] SRC_LANG    = 4'd3;
    localparam logic [3:0] SRC_STR1    = 4'd4;
    localparam logic [3:0] SRC_STR2    = 4'd5;
    localparam logic [3:0] SRC_STR3    = 4'd6;
    localparam logic [3:0] SRC_OS_STR  = 4'd7;
    localparam logic [3:0] SRC_COMPAT  = 4'd8;
    localparam logic [3:0] SRC_PROPS   = 4'd9;
    localparam logic [3:0] SRC_CFG     = 4'd10;
    localparam logic [3:0] SRC_STATUS  = 4'd11;
    localparam logic [3:0] SRC_IFACE   = 4'd12;
    localparam logic [3:0] SRC_NONE    = 4'd13;

    // Longest source in bytes.
    localparam logic [7:0] MAX_SEND_LEN = 8'd142;

    typedef enum logic [1:0] {
        ACT_SEND       = 2'd0,
        ACT_STATUS_IN  = 2'd1,
        ACT_STATUS_OUT = 2'd2,
        ACT_STALL      = 2'd3
    } t_action;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
    } t_req;

    typedef struct packed {
        t_action     action;
        logic        stall_toward_host;
        logic [3:0]  data_source;
        logic [7:0]  send_length;
        logic        configured_now;
    } t_rsp;

    // Full length of each data source.
    function automatic logic [7:0] src_len(input logic [3:0] src);
        logic [7:0] len;
        case (src)
            SRC_DEVICE: len = 8'd18;
            SRC_CONFIG: len = 8'd32;
            SRC_BOS:    len = 8'd22;
            SRC_LANG:   len = 8'd4;
            SRC_STR1:   len = 8'd20;
            SRC_STR2:   len = 8'd28;
            SRC_STR3:   len = 8'd10;
            SRC_OS_STR: len = 8'd18;
            SRC_COMPAT: len = 8'd40;
            SRC_PROPS:  len = MAX_SEND_LEN;
            SRC_CFG:    len = 8'd1;
            SRC_STATUS: len = 8'd2;
            SRC_IFACE:  len = 8'd1;
            default:    len = 8'd0;
        endcase
        return len;
    endfunction

    // Bytes to send: the smaller of the source length and wLength.
    function automatic logic [7:0] xfer_len(input logic [3:0] src, input logic [15:0] wlen);
        logic [7:0] full;
        full = src_len(src);
        return (wlen < {8'd0, full}) ? wlen[7:0] : full;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ucrr_req_if.sv -----
// Setup request channel: valid, ready and the request fields.
`default_nettype none
interface ucrr_req_if import ucrr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ucrr_rsp_if.sv -----
// Response channel: valid, ready and the response fields.
`default_nettype none
interface ucrr_rsp_if import ucrr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/ucrr_in_stage.sv -----
// Input register that holds one setup request or bus event.
`default_nettype none
module ucrr_in_stage import ucrr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ucrr_req_if.sink    i_req,
    ucrr_req_if.source  o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_data;

    // The register takes a new request whenever it is empty or is being drained.
    assign i_req.ready = !r_valid || o_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_req.ready) begin
            n_valid = i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_data <= i_req.data;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.data  = r_data;

endmodule
`default_nettype wire

// ----- rtl/ucrr_engine.sv -----
// Request decode, configured flag and response register.
`default_nettype none
module ucrr_engine import ucrr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ucrr_req_if.sink    i_req,
    ucrr_rsp_if.source  o_rsp
);

    `include "usb_control_request_responder_assert.svh"

    logic       r_cfg;
    logic       n_cfg;
    logic       r_valid;
    logic       n_valid;
    t_rsp       r_rsp;
    t_rsp       n_rsp;
    logic       take;
    logic [7:0] kind;
    logic [7:0] dtype;
    logic [7:0] dindex;
    logic       dir;
    logic       is_send;
    logic [3:0] src;
    t_action    act;

    // The response register frees up when empty or when its response is taken.
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign take        = i_req.valid && i_req.ready;

    assign kind   = i_req.data.request_type & TYPE_MASK;
    assign dtype  = i_req.data.value_word[15:8];
    assign dindex = i_req.data.value_word[7:0];
    assign dir    = i_req.data.request_type[7];

    // Decode the setup request into one action.
    always_comb begin
        is_send = 1'b0;
        src     = SRC_NONE;
        act     = ACT_STALL;
        n_cfg   = r_cfg;
        if (kind == TYPE_STANDARD && i_req.data.request_code == REQ_GET_DESCRIPTOR) begin
            is_send = 1'b1;
            if (dtype == DT_DEVICE) begin
                src = SRC_DEVICE;
            end else if (dtype == DT_CONFIG) begin
                src = SRC_CONFIG;
            end else if (dtype == DT_BOS) begin
                src = SRC_BOS;
            end else if (dtype == DT_STRING && dindex <= STR_LAST) begin
                src = SRC_LANG + dindex[3:0];
            end else if (dtype == DT_STRING && dindex == STR_OS) begin
                src = SRC_OS_STR;
            end else begin
                is_send = 1'b0;
            end
        end else if (kind == TYPE_VENDOR && i_req.data.request_code == REQ_VENDOR_FEATURE) begin
            is_send = 1'b1;
            if (i_req.data.index_word == VIDX_COMPAT) begin
                src = SRC_COMPAT;
            end else if (i_req.data.index_word == VIDX_PROPS) begin
                src = SRC_PROPS;
            end else begin
                is_send = 1'b0;
            end
        end else if (kind == TYPE_STANDARD
                     && i_req.data.request_code == REQ_SET_CONFIGURATION) begin
            act   = ACT_STATUS_IN;
            n_cfg = (i_req.data.value_word != 16'd0);
        end else if (kind == TYPE_STANDARD
                     && i_req.data.request_code == REQ_GET_CONFIGURATION) begin
            is_send = 1'b1;
            src     = SRC_CFG;
        end else if (kind == TYPE_STANDARD && i_req.data.request_code == REQ_GET_STATUS) begin
            is_send = 1'b1;
            src     = SRC_STATUS;
        end else if (kind == TYPE_STANDARD && (i_req.data.request_code inside
                     {REQ_SET_ADDRESS, REQ_CLEAR_FEATURE, REQ_SET_FEATURE,
                      REQ_SET_INTERFACE})) begin
            act = ACT_STATUS_IN;
        end else if (kind == TYPE_STANDARD
                     && i_req.data.request_code == REQ_GET_INTERFACE) begin
            is_send = 1'b1;
            src     = SRC_IFACE;
        end else if (!dir) begin
            act = ACT_STATUS_OUT;
        end
        if (is_send) begin
            act = ACT_SEND;
        end
        // A bus event clears the flag and makes no response.
        if (i_req.data.opcode == OP_BUS_EVENT) begin
            n_cfg = 1'b0;
        end
    end

    // Assemble the response fields.
    always_comb begin
        n_rsp.action            = act;
        n_rsp.stall_toward_host = (act == ACT_STALL) ? dir : 1'b0;
        n_rsp.data_source       = is_send ? src : SRC_NONE;
        n_rsp.send_length       = is_send ? xfer_len(src, i_req.data.length_word) : 8'd0;
        n_rsp.configured_now    = n_cfg;
    end

    // Response valid follows each accepted setup request.
    always_comb begin
        n_valid = r_valid;
        if (i_req.ready) begin
            n_valid = take && (i_req.data.opcode == OP_SETUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cfg   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (take) begin
                r_cfg <= n_cfg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_rsp;

    // A bus event leaves no response and an unconfigured device behind.
    `UCRR_ASSERT_NEXT(a_event_clears, take && i_req.data.opcode == OP_BUS_EVENT,
        !r_valid && !r_cfg, "bus event left a response or the configured flag")
    // A nonzero SET_CONFIGURATION sets the flag and answers with status IN.
    `UCRR_ASSERT_NEXT(a_set_config, take && i_req.data.opcode == OP_SETUP
        && kind == TYPE_STANDARD && i_req.data.request_code == REQ_SET_CONFIGURATION
        && i_req.data.value_word != 16'd0,
        r_cfg && r_valid && r_rsp.action == ACT_STATUS_IN && r_rsp.configured_now,
        "SET_CONFIGURATION did not configure the device")
    // A data send always names a real source and a bounded length.
    `UCRR_ASSERT_NOW(a_send_fields, r_valid && r_rsp.action == ACT_SEND,
        r_rsp.data_source != SRC_NONE && r_rsp.send_length <= MAX_SEND_LEN,
        "data send with no source or an oversized length")
    // Fields that only a send carries stay neutral on other actions.
    `UCRR_ASSERT_NOW(a_plain_fields, r_valid && r_rsp.action != ACT_SEND,
        r_rsp.data_source == SRC_NONE && r_rsp.send_length == 8'd0,
        "non-send response carries a source or length")

endmodule
`default_nettype wire

// ----- rtl/usb_control_request_responder.sv -----
// Top level of the endpoint-0 standard request responder.
//
//   Channel  Dir  Carries                                       Handshake
//   i_req    in   opcode, bmRequestType, bRequest, wValue,      valid/ready
//                 wIndex, wLength
//   o_rsp    out  action, stall direction, source, length,      valid/ready
//                 configured flag
//
// A request is registered, decoded by the engine and its response registered
// in the response register before it is offered. While responses are taken,
// one request per cycle is accepted; the decode depth is set by the chain of
// bRequest and descriptor compares. Reset clears the configured flag and both
// valid bits. A stalled response holds the engine, and the input register
// still takes one more request while it waits. Bus events make no response.
`default_nettype none
module usb_control_request_responder import ucrr_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ucrr_req_if.sink    i_req,
    ucrr_rsp_if.source  o_rsp
);

    ucrr_req_if u_mid_req ();

    // Input register.
    ucrr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_req   (u_mid_req.source)
    );

    // Decode and response register.
    ucrr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_mid_req.sink),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire
